### rtl/bpa_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the bitmap page allocator.
// No dependencies; imported by bitmap_page_allocator_core.
package bpa_pkg;

  // Map geometry: one bit per page, eight pages per map word.
  localparam int NUM_PAGES   = 4096;
  localparam int PAGE_BYTES  = 4096;  // power of two
  localparam int PAGE_SHIFT  = $clog2(PAGE_BYTES);
  localparam int WORD_BITS   = 8;
  localparam int MAP_WORDS   = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int ADDR_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int PAGE_W      = ADDR_W + 3;

  // Port field widths.
  localparam int OPCODE_W    = 3;
  localparam int INDEX_W     = 12;
  localparam int REGION_W    = 32;
  localparam int FREE_PAGE_W = 12;

  localparam logic [WORD_BITS-1:0] WORD_FULL        = 8'hFF;
  localparam logic [REGION_W-1:0]  REGION_AVAILABLE = 32'd1;

  typedef enum logic [OPCODE_W-1:0] {
    OP_ALLOC  = 3'd0,
    OP_FREE   = 3'd1,
    OP_TEST   = 3'd2,
    OP_FIND   = 3'd3,
    OP_FILL   = 3'd4,
    OP_REGION = 3'd5
  } op_e;

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_PAGE   = 5'b00100,
    ST_FIND   = 5'b01000,
    ST_REGION = 5'b10000
  } state_e;

endpackage

### rtl/bpa_ram.sv
`timescale 1ns / 1ps
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module bpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

### rtl/bitmap_page_allocator_core.sv
`timescale 1ns / 1ps
// Bitmap physical page allocator: 4096 pages, one bit each (1 = used).
// Allocate/free/test answer on done_o once the addressed map word has been read; find reads
// one map word per cycle until a clear bit or the last word; region free, mark-all, unused
// ops and out-of-range page ops answer next cycle. Only one word is in flight; the next is
// taken once busy drops. Region free and mark-all answer first, then sweep the map while busy.
// Reset: a sweep of all 512 map words fills the map with ones while busy is high; no done_o for it.
// Depends on bpa_pkg and bpa_ram.
module bitmap_page_allocator_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [bpa_pkg::OPCODE_W-1:0]      opcode_i,
  input  logic [bpa_pkg::INDEX_W-1:0]       block_index_i,
  input  logic [bpa_pkg::REGION_W-1:0]      region_base_i,
  input  logic [bpa_pkg::REGION_W-1:0]      region_length_i,
  input  logic [bpa_pkg::REGION_W-1:0]      region_type_i,
  output logic                              done_o,
  output logic                              page_used_o,
  output logic                              found_o,
  output logic [bpa_pkg::FREE_PAGE_W-1:0]   free_page_o
);
  import bpa_pkg::*;

  localparam logic [ADDR_W-1:0] LAST_WORD = ADDR_W'(MAP_WORDS - 1);

  // Control state
  state_e state_q, state_d;
  logic   done_q, done_d;

  // Walk address: word whose read data is valid this cycle
  logic [ADDR_W-1:0] addr_q, addr_d;

  // Latched item payload
  op_e               op_q, op_d;
  logic [2:0]        bit_q, bit_d;
  logic [PAGE_W-1:0] lo_q, lo_d;      // first page of region
  logic [PAGE_W:0]   hi_q, hi_d;      // one past last page, clamped to map
  logic [ADDR_W-1:0] last_q, last_d;  // last map word of region

  // Result word
  logic                   page_used_q, page_used_d;
  logic                   found_q, found_d;
  logic [FREE_PAGE_W-1:0] free_page_q, free_page_d;

  // RAM port
  logic                 ram_we;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [WORD_BITS-1:0] ram_rdata;

  bpa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (addr_q),
    .wdata_i (ram_wdata),
    .raddr_i (addr_d),
    .rdata_o (ram_rdata)
  );

  // Single-page decode
  logic              idx_in_map;
  logic [PAGE_W-1:0] idx_page;
  logic [7:0]        bit_mask;

  assign idx_in_map = 32'(block_index_i) < 32'(NUM_PAGES);
  assign idx_page   = PAGE_W'(block_index_i);
  assign bit_mask   = 8'(1) << bit_q;

  // Region decode: page range [start, start + count), clipped to the map
  logic [REGION_W-1:0] reg_start, reg_count;
  logic [REGION_W:0]   reg_end, reg_end_clip;
  logic                reg_hit;
  logic [PAGE_W:0]     reg_hi, reg_hi_m1;

  assign reg_start    = region_base_i >> PAGE_SHIFT;
  assign reg_count    = region_length_i >> PAGE_SHIFT;
  assign reg_end      = {1'b0, reg_start} + {1'b0, reg_count};
  assign reg_end_clip = (reg_end > 33'(NUM_PAGES)) ? 33'(NUM_PAGES) : reg_end;
  assign reg_hit      = (region_type_i == REGION_AVAILABLE) &&
                        (reg_start < 32'(NUM_PAGES)) && (reg_count != '0);
  assign reg_hi       = reg_end_clip[PAGE_W:0];
  assign reg_hi_m1    = reg_hi - (PAGE_W + 1)'(1);

  // Bits of the current word that fall inside the region
  logic [7:0] clr_mask;
  always_comb begin
    logic [PAGE_W-1:0] pg;
    for (int j = 0; j < 8; j++) begin
      pg          = {addr_q, 3'(j)};
      clr_mask[j] = (pg >= lo_q) && ({1'b0, pg} < hi_q);
    end
  end

  // Lowest clear bit of the word read
  logic [2:0] low_zero;
  always_comb begin
    low_zero = '0;
    for (int j = 7; j >= 0; j--) begin
      if (!ram_rdata[j]) begin
        low_zero = 3'(j);
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    addr_d      = addr_q;
    op_d        = op_q;
    bit_d       = bit_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    last_d      = last_q;
    done_d      = 1'b0;
    page_used_d = 1'b0;
    found_d     = 1'b0;
    free_page_d = '0;
    ram_we      = 1'b0;
    ram_wdata   = ram_rdata;

    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = WORD_FULL;
        if (addr_q == LAST_WORD) begin
          state_d = ST_IDLE;
        end else begin
          addr_d = addr_q + ADDR_W'(1);
        end
      end

      ST_IDLE: begin
        if (start) begin
          op_d  = op_e'(opcode_i);
          bit_d = block_index_i[2:0];
          unique case (op_e'(opcode_i))
            OP_ALLOC, OP_FREE, OP_TEST: begin
              if (idx_in_map) begin
                addr_d  = idx_page[PAGE_W-1:3];
                state_d = ST_PAGE;
              end else begin
                done_d = 1'b1;
              end
            end
            OP_FIND: begin
              addr_d  = '0;
              state_d = ST_FIND;
            end
            OP_FILL: begin
              // result is all zero, so answer now and sweep afterwards
              done_d  = 1'b1;
              addr_d  = '0;
              state_d = ST_CLEAR;
            end
            OP_REGION: begin
              done_d = 1'b1;
              if (reg_hit) begin
                lo_d    = reg_start[PAGE_W-1:0];
                hi_d    = reg_hi;
                last_d  = reg_hi_m1[PAGE_W-1:3];
                addr_d  = reg_start[PAGE_W-1:3];
                state_d = ST_REGION;
              end
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end

      ST_PAGE: begin
        done_d  = 1'b1;
        state_d = ST_IDLE;
        if (op_q == OP_TEST) begin
          page_used_d = ram_rdata[bit_q];
        end else begin
          ram_we    = 1'b1;
          ram_wdata = (op_q == OP_ALLOC) ? (ram_rdata | bit_mask) : (ram_rdata & ~bit_mask);
        end
      end

      ST_FIND: begin
        if (ram_rdata != WORD_FULL) begin
          done_d      = 1'b1;
          found_d     = 1'b1;
          free_page_d = FREE_PAGE_W'({addr_q, low_zero});
          state_d     = ST_IDLE;
        end else if (addr_q == LAST_WORD) begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          addr_d = addr_q + ADDR_W'(1);
        end
      end

      ST_REGION: begin
        // read of the next word overlaps the write of this one
        ram_we    = 1'b1;
        ram_wdata = ram_rdata & ~clr_mask;
        if (addr_q == last_q) begin
          state_d = ST_IDLE;
        end else begin
          addr_d = addr_q + ADDR_W'(1);
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      addr_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      addr_q  <= addr_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    bit_q       <= bit_d;
    lo_q        <= lo_d;
    hi_q        <= hi_d;
    last_q      <= last_d;
    page_used_q <= page_used_d;
    found_q     <= found_d;
    free_page_q <= free_page_d;
  end

  assign busy        = (state_q != ST_IDLE);
  assign done_o      = done_q;
  assign page_used_o = page_used_q;
  assign found_o     = found_q;
  assign free_page_o = free_page_q;

  // Checks
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("state register not one-hot");

  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || done_o))
    else $error("accepted word neither in progress nor answered");

  a_found_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (found_o || page_used_o) |-> done_o)
    else $error("result flag without done strobe");

  a_used_not_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    page_used_o |-> !found_o)
    else $error("test and find flags both set");

  a_write_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> ((state_q == ST_CLEAR) || (state_q == ST_PAGE) || (state_q == ST_REGION)))
    else $error("map written outside a write state");

endmodule
